// ===== rtl/core/bmpd_pkg.sv =====
// Shared types and constants for the BMP pixel stream decoder.
// Holds opcodes, format and status codes, the decode job record and colour tables.
// No dependencies.
package bmpd_pkg;

  localparam logic [1:0] OP_PALETTE = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_DATA    = 2'd2;
  localparam logic [1:0] OP_END     = 2'd3;

  localparam logic [1:0] ST_SPAN  = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  localparam logic [3:0] FMT_IDX1   = 4'd0;
  localparam logic [3:0] FMT_IDX4   = 4'd1;
  localparam logic [3:0] FMT_IDX8   = 4'd2;
  localparam logic [3:0] FMT_RGB555 = 4'd3;
  localparam logic [3:0] FMT_RGB565 = 4'd4;
  localparam logic [3:0] FMT_BGR24  = 4'd5;
  localparam logic [3:0] FMT_BGRX32 = 4'd6;
  localparam logic [3:0] FMT_BGRA32 = 4'd7;
  localparam logic [3:0] FMT_RLE4   = 4'd8;
  localparam logic [3:0] FMT_RLE8   = 4'd9;

  localparam logic [2:0] CFG_FORMAT   = 3'd0;
  localparam logic [2:0] CFG_WIDTH    = 3'd1;
  localparam logic [2:0] CFG_HEIGHT   = 3'd2;
  localparam logic [2:0] CFG_TOP_DOWN = 3'd3;
  localparam logic [2:0] CFG_PAL_CNT  = 3'd4;

  typedef enum logic [2:0] {
    RLE_COUNT,
    RLE_VALUE,
    RLE_DELTA_X,
    RLE_DELTA_Y,
    RLE_ABS,
    RLE_PAD
  } rle_phase_t;

  typedef enum logic [1:0] {
    JOB_BITS,
    JOB_PAL,
    JOB_RGB
  } job_mode_t;

  // Results of one input item: nspan spans, then an optional status result.
  typedef struct packed {
    job_mode_t   mode;
    logic [3:0]  nspan;
    logic        tail;
    logic [1:0]  tail_status;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  len;
    logic [7:0]  bits;
    logic [31:0] color;
  } job_t;

  typedef logic [31:0][7:0] exp5_t;
  typedef logic [63:0][7:0] exp6_t;

  function automatic exp5_t build_exp5();
    exp5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255 + 15) / 31);
    end
    return t;
  endfunction

  function automatic exp6_t build_exp6();
    exp6_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255 + 31) / 63);
    end
    return t;
  endfunction

  localparam exp5_t EXP5 = build_exp5();
  localparam exp6_t EXP6 = build_exp6();

  // Palette entry is BGR with blue low; result is RGBA with red low.
  function automatic logic [31:0] pal_rgba(input logic [23:0] v);
    return {8'hFF, v[7:0], v[15:8], v[23:16]};
  endfunction

endpackage

// ===== rtl/core/bmpd_palette_ram.sv =====
// Palette memory: one write port, two registered read ports.
// Depends on nothing.
module bmpd_palette_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [23:0]   rdata0,
  output logic [23:0]   rdata1
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next job needs the ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== rtl/core/bmpd_byte_decoder.sv =====
// Decode control: configuration registers, row/column/RLE state and job building.
// Depends on bmpd_pkg; drives the palette memory ports.
module bmpd_byte_decoder #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256,
  parameter int AW            = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                accept,
  input  logic [1:0]          op,
  input  logic [7:0]          palette_slot,
  input  logic [23:0]         palette_bgr,
  input  logic [7:0]          data_byte,
  output logic                settle,
  output logic                pal_we,
  output logic [AW-1:0]       pal_waddr,
  output logic [23:0]         pal_wdata,
  output logic [AW-1:0]       pal_raddr0,
  output logic [AW-1:0]       pal_raddr1,
  output logic                job_has,
  output bmpd_pkg::job_t      job
);
  import bmpd_pkg::*;

  localparam logic [16:0] MAXW  = 17'(MAX_WIDTH);
  localparam logic [16:0] MAXH  = 17'(MAX_HEIGHT);
  localparam logic [8:0]  DEPTH = 9'(PALETTE_DEPTH);

  logic [3:0]  fmt;
  logic [12:0] width;
  logic [12:0] height;
  logic        top_down;
  logic [8:0]  pal_count;

  logic [15:0] raw, raw_next;
  logic [15:0] stride, stride_next;
  logic        bad, bad_next;
  logic [8:0]  lim, lim_next;

  logic [12:0] col, col_next;
  logic [12:0] row, row_next;
  logic [15:0] pos, pos_next;
  logic [23:0] gather, gather_next;
  logic [1:0]  gphase, gphase_next;
  rle_phase_t  rphase, rphase_next;
  logic [7:0]  hold, hold_next;
  logic [7:0]  left, left_next;
  logic        err_flag, err_next;
  logic        done_flag, done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt       <= FMT_IDX1;
      width     <= 13'd1;
      height    <= 13'd1;
      top_down  <= 1'b0;
      pal_count <= 9'd0;
      settle    <= 1'b1;
    end else begin
      settle <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FORMAT:   fmt       <= cfg_data[3:0];
          CFG_WIDTH:    width     <= cfg_data;
          CFG_HEIGHT:   height    <= cfg_data;
          CFG_TOP_DOWN: top_down  <= cfg_data[0];
          CFG_PAL_CNT:  pal_count <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
  end

  // Values that follow from configuration alone, registered from the configuration registers.
  always_comb begin
    case (fmt)
      FMT_IDX1:               raw_next = ({3'd0, width} + 16'd7) >> 3;
      FMT_IDX4:               raw_next = ({3'd0, width} + 16'd1) >> 1;
      FMT_IDX8:               raw_next = {3'd0, width};
      FMT_RGB555, FMT_RGB565: raw_next = {2'd0, width, 1'b0};
      FMT_BGR24:              raw_next = {2'd0, width, 1'b0} + {3'd0, width};
      default:                raw_next = {1'b0, width, 2'b0};
    endcase
    stride_next = (raw_next + 16'd3) & ~16'd3;
    bad_next = (fmt > FMT_RLE8) || (width == 13'd0) || ({4'd0, width} > MAXW) ||
               (height == 13'd0) || ({4'd0, height} > MAXH);
    lim_next = (pal_count < DEPTH) ? pal_count : DEPTH;
  end

  always_ff @(posedge clk) begin
    raw    <= raw_next;
    stride <= stride_next;
    bad    <= bad_next;
    lim    <= lim_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      pos       <= '0;
      gather    <= '0;
      gphase    <= '0;
      rphase    <= RLE_COUNT;
      hold      <= '0;
      left      <= '0;
      err_flag  <= 1'b0;
      done_flag <= 1'b0;
    end else if (accept) begin
      col       <= col_next;
      row       <= row_next;
      pos       <= pos_next;
      gather    <= gather_next;
      gphase    <= gphase_next;
      rphase    <= rphase_next;
      hold      <= hold_next;
      left      <= left_next;
      err_flag  <= err_next;
      done_flag <= done_next;
    end
  end

  function automatic job_t pal_job(input job_t base, input logic [7:0] len,
                                   input logic [7:0] i0, input logic [7:0] i1,
                                   input logic [8:0] lm);
    job_t j;
    j = base;
    j.mode = JOB_PAL;
    if ({1'b0, i0} >= lm) begin
      j.nspan = 4'd0;
      j.tail = 1'b1;
      j.tail_status = ST_ERROR;
    end else if (len >= 8'd2 && {1'b0, i1} >= lm) begin
      j.nspan = 4'd1;
      j.len = 8'd1;
      j.tail = 1'b1;
      j.tail_status = ST_ERROR;
    end else begin
      j.nspan = 4'd1;
      j.len = len;
    end
    return j;
  endfunction

  logic [12:0] row_flip;
  logic [13:0] rem;
  logic [3:0]  n1;
  logic        found;
  logic [3:0]  first_bad;
  logic [15:0] p16;
  logic [7:0]  cr, cg, cb, ca;
  logic        four;
  logic [7:0]  hi_idx, lo_idx;
  logic [7:0]  abs_n;
  logic [7:0]  left_sub;
  logic [8:0]  packed_cnt;
  logic        row_over;
  logic [13:0] col_b, col_h, row_b;

  always_comb begin
    col_next    = col;
    row_next    = row;
    pos_next    = pos;
    gather_next = gather;
    gphase_next = gphase;
    rphase_next = rphase;
    hold_next   = hold;
    left_next   = left;
    err_next    = err_flag;
    done_next   = done_flag;
    pal_we      = 1'b0;
    pal_waddr   = palette_slot[AW-1:0];
    pal_wdata   = palette_bgr;
    pal_raddr0  = '0;
    pal_raddr1  = '0;

    row_flip = top_down ? row : (height - 13'd1 - row);
    job = '0;
    job.mode = JOB_RGB;
    job.row = row_flip[11:0];
    job.col = col[11:0];
    job.len = 8'd1;

    rem = {1'b0, width} - {1'b0, col};
    n1 = (col >= width) ? 4'd0 : ((rem >= 14'd8) ? 4'd8 : rem[3:0]);
    found = 1'b0;
    first_bad = 4'd0;
    p16 = {data_byte, gather[7:0]};
    cr = 8'd0;
    cg = 8'd0;
    cb = 8'd0;
    ca = 8'hFF;
    four = (fmt == FMT_RLE4);
    hi_idx = four ? {4'd0, data_byte[7:4]} : data_byte;
    lo_idx = four ? {4'd0, data_byte[3:0]} : data_byte;
    abs_n = (four && left >= 8'd2) ? 8'd2 : 8'd1;
    left_sub = left - abs_n;
    packed_cnt = four ? (({1'b0, hold} + 9'd1) >> 1) : {1'b0, hold};
    row_over = (row >= height);
    col_b = {1'b0, col} + {6'd0, data_byte};
    col_h = {1'b0, col} + {6'd0, hold};
    row_b = {1'b0, row} + {6'd0, data_byte};

    case (op)
      OP_PALETTE: begin
        pal_we = ({1'b0, palette_slot} < DEPTH);
      end
      OP_START: begin
        col_next    = '0;
        row_next    = '0;
        pos_next    = '0;
        gather_next = '0;
        gphase_next = '0;
        rphase_next = RLE_COUNT;
        hold_next   = '0;
        left_next   = '0;
        err_next    = 1'b0;
        done_next   = 1'b0;
        if (bad) begin
          job.tail = 1'b1;
          job.tail_status = ST_ERROR;
        end
      end
      OP_DATA: begin
        if (!err_flag && !done_flag) begin
          if (bad) begin
            job.tail = 1'b1;
            job.tail_status = ST_ERROR;
          end else if (fmt >= FMT_RLE4) begin
            pal_raddr0 = hi_idx[AW-1:0];
            pal_raddr1 = lo_idx[AW-1:0];
            case (rphase)
              RLE_VALUE: begin
                rphase_next = RLE_COUNT;
                if (hold != 8'd0) begin
                  if (row_over || col_h > {1'b0, width}) begin
                    job.tail = 1'b1;
                    job.tail_status = ST_ERROR;
                  end else begin
                    job = pal_job(job, hold, hi_idx, lo_idx, lim);
                    col_next = col_h[12:0];
                  end
                end else if (data_byte == 8'd0) begin
                  if (row_over) begin
                    job.tail = 1'b1;
                    job.tail_status = ST_ERROR;
                  end else begin
                    col_next = '0;
                    row_next = row + 13'd1;
                  end
                end else if (data_byte == 8'd1) begin
                  done_next = 1'b1;
                end else if (data_byte == 8'd2) begin
                  rphase_next = RLE_DELTA_X;
                end else begin
                  if (row_over || col_b > {1'b0, width}) begin
                    job.tail = 1'b1;
                    job.tail_status = ST_ERROR;
                  end else begin
                    hold_next = data_byte;
                    left_next = data_byte;
                    rphase_next = RLE_ABS;
                  end
                end
              end
              RLE_DELTA_X: begin
                hold_next = data_byte;
                rphase_next = RLE_DELTA_Y;
              end
              RLE_DELTA_Y: begin
                rphase_next = RLE_COUNT;
                if (col_h > {1'b0, width} || row_b > {1'b0, height}) begin
                  job.tail = 1'b1;
                  job.tail_status = ST_ERROR;
                end else begin
                  col_next = col_h[12:0];
                  row_next = row_b[12:0];
                end
              end
              RLE_ABS: begin
                job = pal_job(job, four ? abs_n : 8'd1, hi_idx, lo_idx, lim);
                if (!job.tail) begin
                  col_next = col + {5'd0, abs_n};
                  left_next = left_sub;
                  if (left_sub == 8'd0) begin
                    rphase_next = packed_cnt[0] ? RLE_PAD : RLE_COUNT;
                  end
                end
              end
              RLE_PAD: begin
                rphase_next = RLE_COUNT;
              end
              default: begin
                hold_next = data_byte;
                rphase_next = RLE_VALUE;
              end
            endcase
          end else begin
            if (pos < raw) begin
              case (fmt)
                FMT_IDX1: begin
                  pal_raddr0 = AW'(0);
                  pal_raddr1 = AW'(1);
                  job.mode = JOB_BITS;
                  for (int i = 0; i < 8; i++) begin
                    job.bits[i] = data_byte[7-i];
                    if (!found && 4'(i) < n1 &&
                        (data_byte[7-i] ? (lim < 9'd2) : (lim == 9'd0))) begin
                      found = 1'b1;
                      first_bad = 4'(i);
                    end
                  end
                  job.nspan = found ? first_bad : n1;
                  job.tail = found;
                  job.tail_status = ST_ERROR;
                  col_next = col + {9'd0, n1};
                end
                FMT_IDX4: begin
                  pal_raddr0 = AW'(data_byte[7:4]);
                  pal_raddr1 = AW'(data_byte[3:0]);
                  job = pal_job(job, (rem >= 14'd2) ? 8'd2 : 8'd1,
                                {4'd0, data_byte[7:4]}, {4'd0, data_byte[3:0]}, lim);
                  col_next = col + ((rem >= 14'd2) ? 13'd2 : 13'd1);
                end
                FMT_IDX8: begin
                  pal_raddr0 = data_byte[AW-1:0];
                  pal_raddr1 = data_byte[AW-1:0];
                  job = pal_job(job, 8'd1, data_byte, data_byte, lim);
                  col_next = col + 13'd1;
                end
                FMT_RGB555, FMT_RGB565: begin
                  if (gphase == 2'd0) begin
                    gather_next = {16'd0, data_byte};
                    gphase_next = 2'd1;
                  end else begin
                    gphase_next = 2'd0;
                    if (fmt == FMT_RGB565) begin
                      cr = EXP5[p16[15:11]];
                      cg = EXP6[p16[10:5]];
                    end else begin
                      cr = EXP5[p16[14:10]];
                      cg = EXP5[p16[9:5]];
                    end
                    cb = EXP5[p16[4:0]];
                    job.nspan = 4'd1;
                    job.color = {ca, cb, cg, cr};
                    col_next = col + 13'd1;
                  end
                end
                default: begin
                  if (gphase < ((fmt == FMT_BGR24) ? 2'd2 : 2'd3)) begin
                    case (gphase)
                      2'd0:    gather_next = {16'd0, data_byte};
                      2'd1:    gather_next[15:8] = data_byte;
                      default: gather_next[23:16] = data_byte;
                    endcase
                    gphase_next = gphase + 2'd1;
                  end else begin
                    gphase_next = 2'd0;
                    if (fmt == FMT_BGR24) begin
                      cr = data_byte;
                      cg = gather[15:8];
                      cb = gather[7:0];
                    end else begin
                      cr = gather[23:16];
                      cg = gather[15:8];
                      cb = gather[7:0];
                      ca = (fmt == FMT_BGRA32) ? data_byte : 8'hFF;
                    end
                    job.nspan = 4'd1;
                    job.color = {ca, cb, cg, cr};
                    col_next = col + 13'd1;
                  end
                end
              endcase
            end
            // Advance the row byte count unless a palette fault stopped the byte.
            if (!job.tail) begin
              pos_next = pos + 16'd1;
              if ({1'b0, pos} + 17'd1 >= {1'b0, stride}) begin
                pos_next = '0;
                col_next = '0;
                gphase_next = '0;
                gather_next = '0;
                row_next = row + 13'd1;
                if (row + 13'd1 >= height) begin
                  done_next = 1'b1;
                end
              end
            end
          end
        end
      end
      default: begin
        job.tail = 1'b1;
        job.tail_status = (done_flag && !err_flag) ? ST_DONE : ST_ERROR;
      end
    endcase

    if (op != OP_END && job.tail) begin
      err_next = 1'b1;
    end
    job_has = (job.nspan != 4'd0) || job.tail;
  end

endmodule

// ===== rtl/core/bmpd_span_emitter.sv =====
// Result sequencer: holds one decode job and its palette read data, and
// sends its results one transfer at a time through an output register.
// Depends on bmpd_pkg.
module bmpd_span_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bmpd_pkg::job_t job_in,
  input  logic [23:0]    rdata0,
  input  logic [23:0]    rdata1,
  output logic           free,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [95:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);
  import bmpd_pkg::*;

  job_t        job;
  logic        j_valid;
  logic [3:0]  k;
  logic [3:0]  total;
  logic        cur_last;
  logic        o_load;
  logic [1:0]  r_status;
  logic [11:0] r_col;
  logic [7:0]  r_len;
  logic [31:0] r_c0, r_c1;
  logic [31:0] pal0, pal1;

  always_comb begin
    total    = job.nspan + {3'd0, job.tail};
    cur_last = (k + 4'd1 == total);
    o_load   = j_valid && (!m_tvalid || m_tready);
    free     = !j_valid || (o_load && cur_last);
    pal0     = pal_rgba(rdata0);
    pal1     = pal_rgba(rdata1);

    r_status = job.tail_status;
    r_col    = '0;
    r_len    = '0;
    r_c0     = '0;
    r_c1     = '0;
    if (k < job.nspan) begin
      r_status = ST_SPAN;
      case (job.mode)
        JOB_BITS: begin
          r_col = job.col + {8'd0, k};
          r_len = 8'd1;
          r_c0  = job.bits[k[2:0]] ? pal1 : pal0;
          r_c1  = r_c0;
        end
        JOB_PAL: begin
          r_col = job.col;
          r_len = job.len;
          r_c0  = pal0;
          r_c1  = (job.len >= 8'd2) ? pal1 : pal0;
        end
        default: begin
          r_col = job.col;
          r_len = 8'd1;
          r_c0  = job.color;
          r_c1  = job.color;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
      k       <= '0;
    end else if (load) begin
      j_valid <= 1'b1;
      k       <= '0;
    end else if (o_load) begin
      if (cur_last) begin
        j_valid <= 1'b0;
      end else begin
        k <= k + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      m_tuser <= r_status;
      m_tlast <= cur_last;
      m_tdata <= {r_c1, r_c0, r_len, r_col,
                  (k < job.nspan) ? job.row : 12'd0};
    end
  end

endmodule

// ===== rtl/core/bmp_pixel_stream_decoder_core.sv =====
// BMP pixel stream decoder, top level.
// Depends on bmpd_pkg, bmpd_palette_ram, bmpd_byte_decoder and bmpd_span_emitter.
//
// Takes one pixel-area byte, palette load, start or end request per transfer and
// returns RGBA8 pixel spans, error and completion results. An item is taken every
// cycle while the output side drains, as long as each item yields at most one
// result. A 1-bit indexed byte yields up to eight results. A palette fault in a
// 4-bit indexed byte or in an RLE span yields an error result, after a span when
// only the second index is at fault. An item with several results holds the input
// until its last result enters the output register, which takes one result per
// cycle while the output side drains. This is set by the result sequencer, which
// holds one item's results together with the two palette words read for it from
// the dual-read palette memory (registered read). A configuration write holds the
// input for the cycle after it while derived row geometry settles.
module bmp_pixel_stream_decoder_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // palette_slot[7:0], palette_bgr[31:8], data_byte[39:32]
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // out_row[11:0], out_column[23:12], span_length[31:24],
                                 // color_first[63:32], color_second[95:64]
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast
);
  import bmpd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic          accept;
  logic          settle;
  logic          free;
  logic          pal_we;
  logic [AW-1:0] pal_waddr;
  logic [23:0]   pal_wdata;
  logic [AW-1:0] pal_raddr0, pal_raddr1;
  logic [23:0]   rdata0, rdata1;
  logic          job_has;
  logic          job_load;
  job_t          job;

  assign s_tready = free && !settle;
  assign accept   = s_tvalid && s_tready;
  assign job_load = accept && job_has;

  bmpd_byte_decoder #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .AW           (AW)
  ) u_decoder (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .op          (s_tuser),
    .palette_slot(s_tdata[7:0]),
    .palette_bgr (s_tdata[31:8]),
    .data_byte   (s_tdata[39:32]),
    .settle      (settle),
    .pal_we      (pal_we),
    .pal_waddr   (pal_waddr),
    .pal_wdata   (pal_wdata),
    .pal_raddr0  (pal_raddr0),
    .pal_raddr1  (pal_raddr1),
    .job_has     (job_has),
    .job         (job)
  );

  bmpd_palette_ram #(
    .DEPTH(PALETTE_DEPTH),
    .AW   (AW)
  ) u_palette (
    .clk   (clk),
    .we    (accept && pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (job_load),
    .raddr0(pal_raddr0),
    .raddr1(pal_raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  bmpd_span_emitter u_emitter (
    .clk     (clk),
    .rst     (rst),
    .load    (job_load),
    .job_in  (job),
    .rdata0  (rdata0),
    .rdata1  (rdata1),
    .free    (free),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
